/* design/rpn_pkg.sv */
// package for the rpn stack evaluator: widths, codes, beat and control types
package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int DATA_W      = 32;
  localparam int DEPTH_W     = 5;
  localparam int OPC_W       = 3;
  localparam int STAT_W      = 2;
  localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

  typedef enum logic [OPC_W-1:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_DIV,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [OPC_W-1:0]         opcode;
    logic signed [DATA_W-1:0] operand_value;
    logic                     start_expression;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       stack_depth;
    logic [STAT_W-1:0]        status;
  } out_t;

  typedef struct packed {
    logic    capture;
    logic    read_left;
    logic    alu_load;
    logic    div_start;
    logic    div_step;
    logic    div_finish;
    logic    set_status;
    status_e status;
    logic    commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic             full;
    logic             under;
    logic             right_zero;
    logic             div_busy;
    logic             out_free;
  } dp_sts_t;

endpackage

/* design/rpn_ctrl.sv */
// controller state machine for the rpn stack evaluator
module rpn_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rpn_pkg::dp_sts_t     sts_i,
  output rpn_pkg::ctrl_cmd_t   cmd_o
);

  rpn_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpn_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.status = rpn_pkg::ST_OK;
    in_stall_o = (state_q != rpn_pkg::S_IDLE);
    unique case (state_q)
      rpn_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = rpn_pkg::S_CHECK;
        end
      end
      rpn_pkg::S_CHECK: begin
        cmd_o.set_status = 1'b1;
        state_d          = rpn_pkg::S_DONE;
        unique case (sts_i.opcode) inside
          rpn_pkg::OP_PUSH: begin
            if (sts_i.full) begin
              cmd_o.status = rpn_pkg::ST_OVER;
            end
          end
          rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV: begin
            if (sts_i.under) begin
              cmd_o.status = rpn_pkg::ST_UNDER;
            end else if (sts_i.opcode == rpn_pkg::OP_DIV && sts_i.right_zero) begin
              cmd_o.status = rpn_pkg::ST_DIVZ;
            end else begin
              cmd_o.read_left = 1'b1;
              state_d         = rpn_pkg::S_READ;
            end
          end
          default: begin
            // unused opcodes leave the stack alone
          end
        endcase
      end
      rpn_pkg::S_READ: begin
        if (sts_i.opcode == rpn_pkg::OP_DIV) begin
          cmd_o.div_start = 1'b1;
          state_d         = rpn_pkg::S_DIV;
        end else begin
          cmd_o.alu_load = 1'b1;
          state_d        = rpn_pkg::S_DONE;
        end
      end
      rpn_pkg::S_DIV: begin
        if (sts_i.div_busy) begin
          cmd_o.div_step = 1'b1;
        end else begin
          cmd_o.div_finish = 1'b1;
          state_d          = rpn_pkg::S_DONE;
        end
      end
      rpn_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = rpn_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rpn_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* design/rpn_dp.sv */
// datapath for the rpn stack evaluator: stack memory, alu, divider, output register
module rpn_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rpn_pkg::in_t        in_data_i,
  input  rpn_pkg::ctrl_cmd_t  cmd_i,
  output rpn_pkg::dp_sts_t    sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rpn_pkg::out_t       out_data_o
);

  localparam int DW = rpn_pkg::DATA_W;

  logic [DW-1:0]               mem [rpn_pkg::STACK_DEPTH];

  rpn_pkg::in_t                tok_q;
  logic [rpn_pkg::PTR_W-1:0]   sp_q, esp_q, sp_d;
  logic [DW-1:0]               top_q, top_d;
  logic [DW-1:0]               left_q, res_q, res_d;
  rpn_pkg::status_e            status_q;
  logic                        out_valid_q;
  rpn_pkg::out_t               out_q;

  logic [DW-1:0]               div_quo_q, div_rem_q, div_den_q;
  logic                        div_neg_q;
  logic [rpn_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic [DW:0]                 div_trial;
  logic [2*DW-1:0]             prod;

  logic [rpn_pkg::IDX_W-1:0]   rd_idx, wr_idx;
  logic                        ok, is_push, is_arith, mem_we;

  assign rd_idx   = rpn_pkg::IDX_W'(esp_q - rpn_pkg::PTR_W'(2));
  assign ok       = (status_q == rpn_pkg::ST_OK);
  assign is_push  = (tok_q.opcode == rpn_pkg::OP_PUSH);
  assign is_arith = (tok_q.opcode == rpn_pkg::OP_ADD) || (tok_q.opcode == rpn_pkg::OP_SUB) ||
                    (tok_q.opcode == rpn_pkg::OP_MUL) || (tok_q.opcode == rpn_pkg::OP_DIV);

  // status toward the controller
  assign sts_o.opcode     = tok_q.opcode;
  assign sts_o.full       = (esp_q == rpn_pkg::PTR_W'(rpn_pkg::STACK_DEPTH));
  assign sts_o.under      = (esp_q < rpn_pkg::PTR_W'(2));
  assign sts_o.right_zero = (top_q == '0);
  assign sts_o.div_busy   = (div_cnt_q != '0);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // commit values
  always_comb begin
    sp_d   = esp_q;
    top_d  = top_q;
    mem_we = 1'b0;
    wr_idx = rd_idx;
    if (ok && is_push) begin
      sp_d   = esp_q + rpn_pkg::PTR_W'(1);
      top_d  = tok_q.operand_value;
      mem_we = cmd_i.commit;
      wr_idx = rpn_pkg::IDX_W'(esp_q);
    end else if (ok && is_arith) begin
      sp_d   = esp_q - rpn_pkg::PTR_W'(1);
      top_d  = res_q;
      mem_we = cmd_i.commit;
    end
  end

  // alu
  assign prod = left_q * top_q;
  always_comb begin
    res_d = res_q;
    case (tok_q.opcode)
      rpn_pkg::OP_ADD: res_d = left_q + top_q;
      rpn_pkg::OP_SUB: res_d = left_q - top_q;
      rpn_pkg::OP_MUL: res_d = prod[DW-1:0];
      default:         res_d = res_q;
    endcase
  end

  // restoring divider step on magnitudes
  assign div_trial = {div_rem_q, div_quo_q[DW-1]} - {1'b0, div_den_q};

  // stack memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.read_left) begin
      left_q <= mem[rd_idx];
    end
    if (mem_we) begin
      mem[wr_idx] <= top_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tok_q <= in_data_i;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.alu_load) begin
      res_q <= res_d;
    end else if (cmd_i.div_finish) begin
      res_q <= div_neg_q ? (DW'(0) - div_quo_q) : div_quo_q;
    end
    if (cmd_i.div_start) begin
      div_neg_q <= left_q[DW-1] ^ top_q[DW-1];
      div_quo_q <= left_q[DW-1] ? (DW'(0) - left_q) : left_q;
      div_den_q <= top_q[DW-1] ? (DW'(0) - top_q) : top_q;
      div_rem_q <= '0;
    end else if (cmd_i.div_step && sts_o.div_busy) begin
      if (!div_trial[DW]) begin
        div_rem_q <= div_trial[DW-1:0];
        div_quo_q <= {div_quo_q[DW-2:0], 1'b1};
      end else begin
        div_rem_q <= {div_rem_q[DW-2:0], div_quo_q[DW-1]};
        div_quo_q <= {div_quo_q[DW-2:0], 1'b0};
      end
    end
    if (cmd_i.commit) begin
      top_q             <= top_d;
      out_q.top_value   <= (sp_d != '0) ? top_d : '0;
      out_q.stack_depth <= rpn_pkg::DEPTH_W'(sp_d);
      out_q.status      <= status_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      esp_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        esp_q <= in_data_i.start_expression ? '0 : sp_q;
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= rpn_pkg::DIV_CNT_W'(DW);
      end else if (cmd_i.div_step && sts_o.div_busy) begin
        div_cnt_q <= div_cnt_q - rpn_pkg::DIV_CNT_W'(1);
      end
      if (cmd_i.commit) begin
        sp_q        <= sp_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/rpn_stack_evaluator.sv */
// top level of the rpn stack evaluator: controller plus datapath
// usage:
//   input channel carries one token per beat (opcode, operand_value,
//   start_expression); it is taken when in_valid_i is high and in_stall_o low
//   output channel returns one beat per token: top of stack (zero if empty),
//   depth and status (ok, underflow, overflow, divide by zero)
//   one token is worked on at a time; in_stall_o stays high until its result
//   has been written to the output register
// steps from accept to result valid:
//   push, unused opcode or any error: check, then commit
//   add, subtract, multiply: check, left operand read from stack memory, alu, commit
//   divide: check, operand read, 32 steps of the radix-2 restoring divider, commit
// tokens are not overlapped: each is committed before the next is accepted
// the top entry lives in a register, so operators need only one memory read
// reset: stack pointer cleared (stack empty), output invalid, controller idle;
//   the stack memory is not cleared and needs no clearing pass
// receiver stall: the result waits in the output register; the next token is
//   still accepted and worked on, and its commit waits for the register to free
module rpn_stack_evaluator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rpn_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rpn_pkg::out_t  out_data_o
);

  // command and status between controller and datapath
  rpn_pkg::ctrl_cmd_t cmd;
  rpn_pkg::dp_sts_t   sts;

  // sequencer: check, operand read, alu or divider loop, commit
  rpn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // stack memory, top register, alu, divider and output register
  rpn_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
